// ----- src/ascii_to_display_code_packer_macros.svh -----
// ---------------------------------------------------------------------------
// ascii_to_display_code_packer_macros.svh
// Assertion macros for the display code packer. Bodies vanish in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASCII_TO_DISPLAY_CODE_PACKER_MACROS_SVH
`define ASCII_TO_DISPLAY_CODE_PACKER_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every clock edge once reset is released.
`define ADCP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("display code packer check failed");

// Checked on every clock edge, including while reset is held.
`define ADCP_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("display code packer check failed");

`else

`define ADCP_ASSERT(label, prop)
`define ADCP_ASSERT_ALWAYS(label, prop)

`endif

`endif

// ----- src/adcp_pkg.sv -----
// ---------------------------------------------------------------------------
// adcp_pkg
// Types, constants and the character code table of the display code packer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package adcp_pkg;

  localparam int CODE_W         = 6;
  localparam int WORD_W         = 60;
  localparam int CODES_PER_WORD = 10;
  localparam int BURST_BYTES    = 15;
  localparam int BURST_W        = BURST_BYTES * 8;

  localparam logic [3:0] LAST_SLOT    = 4'd9;
  localparam logic [3:0] BYTES_NONE   = 4'd0;
  localparam logic [3:0] BYTES_FIRST  = 4'd7;
  localparam logic [3:0] BYTES_SECOND = 4'd8;
  localparam logic [3:0] BYTES_DOUBLE = 4'd15;

  localparam logic       FUNC_CHAR    = 1'b0;
  localparam logic       FUNC_END     = 1'b1;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  typedef struct packed {
    logic       func;
    logic [7:0] char_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // Bytes of one item, left aligned, handed from the packer to the serializer.
  typedef struct packed {
    logic               vld;
    logic [3:0]         count;
    logic [BURST_W-1:0] data;
  } burst_t;

  localparam logic [CODE_W-1:0] CODE_ROM [128] = '{
    6'o00, 6'o00, 6'o00, 6'o00, 6'o00, 6'o00, 6'o00, 6'o00,
    6'o00, 6'o00, 6'o00, 6'o00, 6'o00, 6'o00, 6'o00, 6'o00,
    6'o00, 6'o00, 6'o00, 6'o00, 6'o00, 6'o00, 6'o00, 6'o00,
    6'o00, 6'o00, 6'o00, 6'o00, 6'o00, 6'o00, 6'o00, 6'o00,
    6'o55, 6'o66, 6'o64, 6'o60, 6'o53, 6'o63, 6'o67, 6'o70,
    6'o51, 6'o52, 6'o47, 6'o45, 6'o56, 6'o46, 6'o57, 6'o50,
    6'o33, 6'o34, 6'o35, 6'o36, 6'o37, 6'o40, 6'o41, 6'o42,
    6'o43, 6'o44, 6'o00, 6'o77, 6'o72, 6'o54, 6'o73, 6'o71,
    6'o74, 6'o01, 6'o02, 6'o03, 6'o04, 6'o05, 6'o06, 6'o07,
    6'o10, 6'o11, 6'o12, 6'o13, 6'o14, 6'o15, 6'o16, 6'o17,
    6'o20, 6'o21, 6'o22, 6'o23, 6'o24, 6'o25, 6'o26, 6'o27,
    6'o30, 6'o31, 6'o32, 6'o61, 6'o75, 6'o62, 6'o76, 6'o65,
    6'o00, 6'o01, 6'o02, 6'o03, 6'o04, 6'o05, 6'o06, 6'o07,
    6'o10, 6'o11, 6'o12, 6'o13, 6'o14, 6'o15, 6'o16, 6'o17,
    6'o20, 6'o21, 6'o22, 6'o23, 6'o24, 6'o25, 6'o26, 6'o27,
    6'o30, 6'o31, 6'o32, 6'o61, 6'o00, 6'o00, 6'o00, 6'o00
  };

endpackage

`default_nettype wire

// ----- src/adcp_pack.sv -----
// ---------------------------------------------------------------------------
// adcp_pack
// Input register, word packing state and the byte burst of each item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adcp_pack (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire adcp_pkg::in_item_t in_data,
  input  wire logic              ser_ready,
  output adcp_pkg::burst_t       burst
);

  adcp_pkg::in_item_t item_r;
  logic                               vld_r, vld_nxt;
  logic [adcp_pkg::WORD_W-1:0]        acc_r, acc_nxt, acc_ins, send_w;
  logic [3:0]                         cnt_r, cnt_nxt, slot;
  logic                               first_r, first_nxt;
  logic [3:0]                         carry_r, carry_nxt;
  logic [adcp_pkg::CODE_W-1:0]        code;
  logic                               is_end, is_nl, full, sending, double_w;
  logic [3:0]                         nbytes;
  logic                               adv;

  always_comb begin
    slot = (cnt_r > adcp_pkg::LAST_SLOT) ? adcp_pkg::LAST_SLOT : cnt_r;
    code = adcp_pkg::CODE_ROM[item_r.char_byte[6:0]];

    // Drop the new code into its slot, most significant slot first.
    acc_ins = acc_r;
    for (int i = 0; i < adcp_pkg::CODES_PER_WORD; i++) begin
      if (slot == 4'(i)) begin
        acc_ins[adcp_pkg::WORD_W-1-adcp_pkg::CODE_W*i -: adcp_pkg::CODE_W] =
          acc_r[adcp_pkg::WORD_W-1-adcp_pkg::CODE_W*i -: adcp_pkg::CODE_W] | code;
      end
    end

    is_end   = (item_r.func == adcp_pkg::FUNC_END);
    is_nl    = !is_end && (item_r.char_byte == adcp_pkg::CHAR_NEWLINE);
    full     = !is_end && !is_nl && (slot == adcp_pkg::LAST_SLOT);
    sending  = (is_end && !first_r) || is_nl || full;
    double_w = is_nl && (slot == adcp_pkg::LAST_SLOT);
    send_w   = is_end ? '0 : (is_nl ? acc_r : acc_ins);

    if (!sending) begin
      nbytes = adcp_pkg::BYTES_NONE;
    end else if (double_w) begin
      nbytes = adcp_pkg::BYTES_DOUBLE;
    end else if (first_r) begin
      nbytes = adcp_pkg::BYTES_FIRST;
    end else begin
      nbytes = adcp_pkg::BYTES_SECOND;
    end

    // A zero-byte item never waits on the serializer.
    adv      = vld_r && ((nbytes == adcp_pkg::BYTES_NONE) || ser_ready);
    in_stall = vld_r && !adv;
    vld_nxt  = in_stall ? vld_r : in_valid;

    burst.vld   = adv && sending;
    burst.count = nbytes;
    burst.data  = first_r ? {send_w, 60'd0} : {carry_r, send_w, 56'd0};
  end

  always_comb begin
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    carry_nxt = carry_r;
    if (adv) begin
      if (is_end || is_nl || full) begin
        acc_nxt = '0;
        cnt_nxt = '0;
      end else begin
        acc_nxt = acc_ins;
        cnt_nxt = slot + 4'd1;
      end
      if (sending) begin
        if (double_w) begin
          carry_nxt = '0;
        end else begin
          first_nxt = !first_r;
          carry_nxt = first_r ? send_w[3:0] : 4'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      acc_r   <= '0;
      cnt_r   <= '0;
      first_r <= 1'b1;
      carry_r <= '0;
    end else begin
      vld_r   <= vld_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      first_r <= first_nxt;
      carry_r <= carry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
  end

endmodule

`default_nettype wire

// ----- src/adcp_ser.sv -----
// ---------------------------------------------------------------------------
// adcp_ser
// Byte serializer: holds one burst and sends it one beat per cycle while out_stall is low.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adcp_ser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire adcp_pkg::burst_t   burst,
  output logic                    ser_ready,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output adcp_pkg::out_item_t     out_data
);

  logic [adcp_pkg::BURST_W-1:0] vec_r, vec_nxt;
  logic [3:0]                   rem_r, rem_nxt;
  logic                         take;

  always_comb begin
    out_valid         = (rem_r != 4'd0);
    take              = out_valid && !out_stall;
    out_data.out_byte = vec_r[adcp_pkg::BURST_W-1 -: 8];
    out_data.last     = (rem_r == 4'd1);
    // A new burst may land in the cycle the final beat of the old one leaves.
    ser_ready         = !out_valid || (out_data.last && !out_stall);

    vec_nxt = vec_r;
    rem_nxt = rem_r;
    if (burst.vld) begin
      vec_nxt = burst.data;
      rem_nxt = burst.count;
    end else if (take) begin
      vec_nxt = {vec_r[adcp_pkg::BURST_W-9:0], 8'h00};
      rem_nxt = rem_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vec_r <= vec_nxt;
  end

endmodule

`default_nettype wire

// ----- src/ascii_to_display_code_packer.sv -----
// ---------------------------------------------------------------------------
// ascii_to_display_code_packer
// ASCII to 6-bit display code converter with a packed 60-bit word byte stream.
// ---------------------------------------------------------------------------
// One input beat can be taken every cycle while in_stall is low. A character
// that does not complete a word, and an end beat with nothing pending, produce
// no output. A beat that sends words produces 7, 8 or 15 output beats at one
// per cycle while out_stall is low; the single byte serializer sets the rate
// then, so the next beat that also sends words waits until that burst is down
// to its last byte. Beats pass the input register, then the serializer's byte
// register; the last output beat of each input beat is flagged with last.
`timescale 1ns / 1ps
`default_nettype none

`include "ascii_to_display_code_packer_macros.svh"

module ascii_to_display_code_packer (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire adcp_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output adcp_pkg::out_item_t      out_data
);

  adcp_pkg::burst_t burst;
  logic             ser_ready;

  adcp_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .ser_ready (ser_ready),
    .burst     (burst)
  );

  adcp_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .burst     (burst),
    .ser_ready (ser_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `ADCP_ASSERT(a_burst_len, burst.vld |-> (burst.count == adcp_pkg::BYTES_FIRST || burst.count == adcp_pkg::BYTES_SECOND || burst.count == adcp_pkg::BYTES_DOUBLE))
  `ADCP_ASSERT(a_burst_fits, burst.vld |-> ser_ready)
  `ADCP_ASSERT(a_idle_no_stall, !out_valid |-> !in_stall)
  `ADCP_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid)

endmodule

`default_nettype wire
